// ===== rtl/fbpa_pkg.sv =====
`default_nettype none
package fbpa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W     = 32;
    localparam int BSIZE_W    = 16;
    localparam int NBLK_W     = 7;
    localparam int PROD_W     = IDX_W + BSIZE_W;
    localparam int STATUS_W   = 2;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_POOL_BASE  = 2'd0;
    localparam logic [1:0] REG_BLOCK_SIZE = 2'd1;
    localparam logic [1:0] REG_NUM_BLOCKS = 2'd2;

    localparam logic [ADDR_W-1:0]  RST_POOL_BASE  = '0;
    localparam logic [BSIZE_W-1:0] RST_BLOCK_SIZE = 16'd16;
    localparam logic [NBLK_W-1:0]  RST_NUM_BLOCKS = NBLK_W'(MAX_BLOCKS);

    typedef struct packed {
        logic [ADDR_W-1:0]  pool_base;
        logic [BSIZE_W-1:0] blk_size;
        logic [NBLK_W-1:0]  blk_count;
        logic               reload;
        logic [CNT_W-1:0]   reload_n;
    } t_cfg;

endpackage
`default_nettype wire

// ===== rtl/fbpa_ram.sv =====
`default_nettype none
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/fbpa_div.sv =====
`default_nettype none
module fbpa_div
    import fbpa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [ADDR_W-1:0]  i_dividend,
    input  wire logic [BSIZE_W-1:0] i_divisor,
    output logic                    o_done,
    output logic      [ADDR_W-1:0]  o_quot,
    output logic      [BSIZE_W-1:0] o_rem
);

    localparam int STEP_W = $clog2(ADDR_W);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_step;
    logic [ADDR_W-1:0]    r_quot;
    logic [BSIZE_W-1:0]   r_rem;
    logic [BSIZE_W-1:0]   r_div;
    logic [BSIZE_W:0]     trial;
    logic                 ge;

    // One quotient bit a cycle, restoring form
    assign trial = {r_rem, r_quot[ADDR_W-1]};
    assign ge    = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(ADDR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[ADDR_W-2:0], ge};
            r_rem  <= ge ? BSIZE_W'(trial - {1'b0, r_div}) : trial[BSIZE_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ===== rtl/fbpa_regs.sv =====
`default_nettype none
module fbpa_regs
    import fbpa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    logic [ADDR_W-1:0]  r_pool_base;
    logic [BSIZE_W-1:0] r_block_size;
    logic [NBLK_W-1:0]  r_num_blocks;
    logic               wr;
    logic [1:0]         reg_idx;
    logic [NBLK_W-1:0]  wr_n;
    logic [NBLK_W-1:0]  sat_n;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr      = psel && penable && pwrite;

    // Clamp the block count to the pool depth
    assign wr_n  = pwdata[NBLK_W-1:0];
    assign sat_n = (wr_n > NBLK_W'(MAX_BLOCKS)) ? NBLK_W'(MAX_BLOCKS) : wr_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base  <= RST_POOL_BASE;
            r_block_size <= RST_BLOCK_SIZE;
            r_num_blocks <= RST_NUM_BLOCKS;
        end else if (wr) begin
            case (reg_idx)
                REG_POOL_BASE:  r_pool_base  <= pwdata[ADDR_W-1:0];
                REG_BLOCK_SIZE: r_block_size <= pwdata[BSIZE_W-1:0];
                REG_NUM_BLOCKS: r_num_blocks <= sat_n;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_POOL_BASE:  prdata = PDATA_W'(r_pool_base);
            REG_BLOCK_SIZE: prdata = PDATA_W'(r_block_size);
            REG_NUM_BLOCKS: prdata = PDATA_W'(r_num_blocks);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.pool_base = r_pool_base;
    assign o_cfg.blk_size  = r_block_size;
    assign o_cfg.blk_count = r_num_blocks;
    assign o_cfg.reload    = wr && (reg_idx == REG_NUM_BLOCKS);
    assign o_cfg.reload_n  = CNT_W'(sat_n);

endmodule
`default_nettype wire

// ===== rtl/fixed_block_pool_allocator.sv =====
`default_nettype none
// Fixed-size block pool allocator.
// Input channel (i_in_valid / o_in_stall): one beat is a request, i_op = allocate or
// free, i_addr = address to free. Output channel (o_out_valid / i_out_stall): one
// result beat per request with status, block address, allocation map and free count.
// Configuration goes through the APB port: pool base at 0x0, block size at 0x4,
// block count at 0x8. Writing the block count reloads the free stack and clears the map.
// One request is worked on at a time. Allocate runs from the accepting edge to the
// result beat through stack memory read, index times block size, base add, output.
// Free runs the 32-step serial divider that splits the offset from pool_base into
// block index and remainder; a free below pool_base or with block size 0 skips it.
// A finished result sits in the output register; the next request is accepted while
// it waits, and only its own completion holds until the receiver takes that beat.
// Reset restores pool_base 0, block size 16, block count 64 and a full free stack; the
// stack memory needs no clearing pass, since unwritten slots are tracked by a
// low-water mark and read back as their own position.
module fixed_block_pool_allocator
    import fbpa_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic                i_op,
    input  wire logic [ADDR_W-1:0]   i_addr,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic      [STATUS_W-1:0] o_status,
    output logic      [ADDR_W-1:0]   o_block_addr,
    output logic      [MAX_BLOCKS-1:0] o_alloc_map,
    output logic      [CNT_W-1:0]    o_free_count,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POP  = 3'd1;
    localparam logic [2:0] S_ADDR = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    t_cfg cfg;

    logic [2:0]            r_state,   n_state;
    logic [CNT_W-1:0]      r_sc,      n_sc;      // entries on the free stack
    logic [CNT_W-1:0]      r_low,     n_low;     // lowest stack depth since reload
    logic [MAX_BLOCKS-1:0] r_map,     n_map;
    logic [STATUS_W-1:0]   r_status,  n_status;
    logic [ADDR_W-1:0]     r_baddr,   n_baddr;
    logic [PROD_W-1:0]     r_prod,    n_prod;

    logic                  r_out_valid,  n_out_valid;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic [ADDR_W-1:0]     r_out_baddr,  n_out_baddr;
    logic [MAX_BLOCKS-1:0] r_out_map,    n_out_map;
    logic [CNT_W-1:0]      r_out_count,  n_out_count;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_rdata;
    logic [CNT_W-1:0]      sc_m1;
    logic [IDX_W-1:0]      pop_idx;

    logic                  div_start;
    logic                  div_done;
    logic [ADDR_W-1:0]     div_quot;
    logic [BSIZE_W-1:0]    div_rem;
    logic [IDX_W-1:0]      div_idx;
    logic                  free_ok;

    fbpa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Free stack: written on push at the stack top, read one below the top
    fbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_sc[IDX_W-1:0]),
        .i_wdata (div_idx),
        .i_raddr (sc_m1[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    fbpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_addr - cfg.pool_base),
        .i_divisor  (cfg.blk_size),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign sc_m1 = r_sc - 1'b1;

    // Every push since reload lands at or above the low-water mark, so a pop that
    // reaches below it finds a slot still holding its reload value: its own position.
    assign pop_idx = (r_sc == r_low) ? sc_m1[IDX_W-1:0] : ram_rdata;

    assign div_idx = div_quot[IDX_W-1:0];
    assign free_ok = (div_rem == '0)
                  && (div_quot < ADDR_W'(cfg.blk_count))
                  && r_map[div_idx]
                  && (r_sc < CNT_W'(MAX_BLOCKS));

    always_comb begin
        n_state      = r_state;
        n_sc         = r_sc;
        n_low        = r_low;
        n_map        = r_map;
        n_status     = r_status;
        n_baddr      = r_baddr;
        n_prod       = r_prod;
        ram_we       = 1'b0;
        div_start    = 1'b0;
        // drop the held beat once the receiver takes it
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_baddr  = r_out_baddr;
        n_out_map    = r_out_map;
        n_out_count  = r_out_count;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_baddr = '0;
                    if (i_op == OP_ALLOC) begin
                        if (r_sc == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_state  = S_POP;
                        end
                    end else if ((i_addr < cfg.pool_base) || (cfg.blk_size == '0)) begin
                        n_status = ST_BADFREE;
                        n_state  = S_DONE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end
            S_POP: begin
                n_sc = sc_m1;
                if (r_sc == r_low) begin
                    n_low = sc_m1;
                end
                n_map   = r_map | (MAX_BLOCKS'(1) << pop_idx);
                n_prod  = PROD_W'(pop_idx) * PROD_W'(cfg.blk_size);
                n_state = S_ADDR;
            end
            S_ADDR: begin
                n_baddr  = cfg.pool_base + ADDR_W'(r_prod);
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_DIV: begin
                if (div_done) begin
                    if (free_ok) begin
                        // push the index back and release the block
                        ram_we   = 1'b1;
                        n_sc     = r_sc + 1'b1;
                        n_map    = r_map & ~(MAX_BLOCKS'(1) << div_idx);
                        n_status = ST_OK;
                    end else begin
                        n_status = ST_BADFREE;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_baddr  = r_baddr;
                    n_out_map    = r_map;
                    n_out_count  = r_sc;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sc        <= CNT_W'(MAX_BLOCKS);
            r_low       <= CNT_W'(MAX_BLOCKS);
            r_map       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (cfg.reload) begin
                // reload: full stack of indices 0..n-1, nothing allocated
                r_sc  <= cfg.reload_n;
                r_low <= cfg.reload_n;
                r_map <= '0;
            end else begin
                r_sc  <= n_sc;
                r_low <= n_low;
                r_map <= n_map;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status     <= n_status;
        r_baddr      <= n_baddr;
        r_prod       <= n_prod;
        r_out_status <= n_out_status;
        r_out_baddr  <= n_out_baddr;
        r_out_map    <= n_out_map;
        r_out_count  <= n_out_count;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_block_addr = r_out_baddr;
    assign o_alloc_map  = r_out_map;
    assign o_free_count = r_out_count;

endmodule
`default_nettype wire

// ===== tb/sv/fixed_block_pool_allocator_tb.sv =====
`default_nettype none
module fixed_block_pool_allocator_tb;
    import fbpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Spare register slot: writes there must leave the pool untouched.
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam int NUM_SEGMENTS = 6;
    localparam int SEG_ITEMS    = 292;
    localparam int HOLD_SEGMENT = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int BURST_LEN    = 24;
    localparam int SETTLE       = 60;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [ADDR_W-1:0]     blk_addr;
        logic [MAX_BLOCKS-1:0] map;
        logic [CNT_W-1:0]      count;
    } t_result;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    // One directed step: either a register write or a request beat. Request rows
    // with pinned set carry the status, address and free count typed in by hand.
    typedef struct packed {
        t_row_kind           kind;
        logic [PADDR_W-1:0]  cfg_addr;
        logic [PDATA_W-1:0]  cfg_data;
        logic                op;
        logic [ADDR_W-1:0]   addr;
        logic                pinned;
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   blk_addr;
        logic [CNT_W-1:0]    count;
    } t_step;

    localparam int NUM_STEPS = 34;
    localparam t_step DIRECTED_STEPS [NUM_STEPS] = '{
        // reset pool: base 0, 16-byte blocks, 64 blocks, index 63 on top
        '{ROW_REQ, '0, '0, OP_ALLOC, 32'h0000_0000, 1'b1, ST_OK,      32'h0000_03F0, 7'd63},
        '{ROW_REQ, '0, '0, OP_FREE,  32'h0000_0000, 1'b1, ST_BADFREE, 32'h0,         7'd63},
        '{ROW_REQ, '0, '0, OP_FREE,  32'h0000_03F0, 1'b1, ST_OK,      32'h0,         7'd64},
        '{ROW_REQ, '0, '0, OP_FREE,  32'h0000_03F0, 1'b1, ST_BADFREE, 32'h0,         7'd64},
        '{ROW_REQ, '0, '0, OP_FREE,  32'h0000_03F4, 1'b1, ST_BADFREE, 32'h0,         7'd64},
        '{ROW_REQ, '0, '0, OP_FREE,  32'h0000_0400, 1'b1, ST_BADFREE, 32'h0,         7'd64},
        '{ROW_REQ, '0, '0, OP_FREE,  32'hFFFF_FFFF, 1'b1, ST_BADFREE, 32'h0,         7'd64},
        // base near the top, largest block size, two blocks: sums wrap
        '{ROW_CFG, {REG_POOL_BASE, 2'b00},  32'hFFFF_FFF0, OP_ALLOC, '0, 1'b0, '0, '0, '0},
        '{ROW_CFG, {REG_BLOCK_SIZE, 2'b00}, 32'h0000_FFFF, OP_ALLOC, '0, 1'b0, '0, '0, '0},
        '{ROW_CFG, {REG_NUM_BLOCKS, 2'b00}, 32'h0000_0002, OP_ALLOC, '0, 1'b0, '0, '0, '0},
        '{ROW_REQ, '0, '0, OP_ALLOC, 32'hFFFF_FFFF, 1'b1, ST_OK,      32'h0000_FFEF, 7'd1},
        '{ROW_REQ, '0, '0, OP_ALLOC, 32'h0000_0000, 1'b1, ST_OK,      32'hFFFF_FFF0, 7'd0},
        '{ROW_REQ, '0, '0, OP_ALLOC, 32'h0000_0000, 1'b1, ST_EMPTY,   32'h0,         7'd0},
        '{ROW_REQ, '0, '0, OP_FREE,  32'h0000_FFEF, 1'b1, ST_BADFREE, 32'h0,         7'd0},
        '{ROW_REQ, '0, '0, OP_FREE,  32'hFFFF_FFF0, 1'b1, ST_OK,      32'h0,         7'd1},
        '{ROW_REQ, '0, '0, OP_FREE,  32'hFFFF_FFEF, 1'b1, ST_BADFREE, 32'h0,         7'd1},
        // zero block size: every block sits at the base, no free gets through
        '{ROW_CFG, {REG_BLOCK_SIZE, 2'b00}, 32'h0000_0000, OP_ALLOC, '0, 1'b0, '0, '0, '0},
        '{ROW_CFG, {REG_NUM_BLOCKS, 2'b00}, 32'h0000_0003, OP_ALLOC, '0, 1'b0, '0, '0, '0},
        '{ROW_REQ, '0, '0, OP_ALLOC, 32'h0000_0000, 1'b1, ST_OK,      32'hFFFF_FFF0, 7'd2},
        '{ROW_REQ, '0, '0, OP_FREE,  32'hFFFF_FFF0, 1'b1, ST_BADFREE, 32'h0,         7'd2},
        // empty pool
        '{ROW_CFG, {REG_BLOCK_SIZE, 2'b00}, 32'h0000_0001, OP_ALLOC, '0, 1'b0, '0, '0, '0},
        '{ROW_CFG, {REG_NUM_BLOCKS, 2'b00}, 32'h0000_0000, OP_ALLOC, '0, 1'b0, '0, '0, '0},
        '{ROW_REQ, '0, '0, OP_ALLOC, 32'h0000_0000, 1'b1, ST_EMPTY,   32'h0,         7'd0},
        '{ROW_REQ, '0, '0, OP_FREE,  32'hFFFF_FFF0, 1'b1, ST_BADFREE, 32'h0,         7'd0},
        // block count past the limit saturates; spare register is ignored
        '{ROW_CFG, {REG_POOL_BASE, 2'b00},  32'h0000_0000, OP_ALLOC, '0, 1'b0, '0, '0, '0},
        '{ROW_CFG, {REG_NUM_BLOCKS, 2'b00}, 32'h0000_007F, OP_ALLOC, '0, 1'b0, '0, '0, '0},
        '{ROW_CFG, {REG_SPARE, 2'b00},      32'hFFFF_FFFF, OP_ALLOC, '0, 1'b0, '0, '0, '0},
        '{ROW_REQ, '0, '0, OP_ALLOC, 32'h0000_0000, 1'b1, ST_OK,      32'h0000_003F, 7'd63},
        '{ROW_REQ, '0, '0, OP_FREE,  32'h0000_003F, 1'b0, '0,         '0,            '0},
        // upper bits of the block size write are dropped
        '{ROW_CFG, {REG_BLOCK_SIZE, 2'b00}, 32'hABCD_0010, OP_ALLOC, '0, 1'b0, '0, '0, '0},
        '{ROW_CFG, {REG_NUM_BLOCKS, 2'b00}, 32'h0000_0040, OP_ALLOC, '0, 1'b0, '0, '0, '0},
        '{ROW_REQ, '0, '0, OP_ALLOC, 32'h5555_AAAA, 1'b1, ST_OK,      32'h0000_03F0, 7'd63},
        '{ROW_REQ, '0, '0, OP_FREE,  32'h8000_0000, 1'b1, ST_BADFREE, 32'h0,         7'd63},
        '{ROW_REQ, '0, '0, OP_FREE,  32'h0000_03F0, 1'b0, '0,         '0,            '0}
    };

    // DUT-facing signals; every input the bench drives is known from time zero.
    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_op        = OP_ALLOC;
    logic [ADDR_W-1:0]     i_addr      = '0;
    logic                  i_out_stall = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [PADDR_W-1:0]    paddr       = '0;
    logic [PDATA_W-1:0]    pwdata      = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [ADDR_W-1:0]     o_block_addr;
    logic [MAX_BLOCKS-1:0] o_alloc_map;
    logic [CNT_W-1:0]      o_free_count;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    // Hand-typed expectation that travels with the request beat it belongs to.
    bit      pin_on    = 1'b0;
    t_result pin_value = '0;

    // Shadow of the pool: free stack, map and register copies.
    logic [IDX_W-1:0]      free_idx [MAX_BLOCKS];
    logic [CNT_W-1:0]      free_depth;
    logic [MAX_BLOCKS-1:0] busy_map;
    logic [ADDR_W-1:0]     base_reg;
    logic [BSIZE_W-1:0]    size_reg;
    logic [NBLK_W-1:0]     nblk_reg;

    t_result pending_results [$];
    int      mismatches = 0;

    int sender_idle_pct = 10;
    int recv_idle_pct   = 82;
    bit hold_arm        = 1'b0;

    fixed_block_pool_allocator u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_addr       (i_addr),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_block_addr (o_block_addr),
        .o_alloc_map  (o_alloc_map),
        .o_free_count (o_free_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #10ms;
        $display("fixed_block_pool_allocator regression: fail");
        $finish;
    end

    // Refill the stack with 0..n-1 (n-1 on top) and mark every block free.
    function automatic void refill_pool();
        for (int i = 0; i < MAX_BLOCKS; i++)
            free_idx[i] = IDX_W'(i);
        free_depth = CNT_W'(nblk_reg);
        busy_map   = '0;
    endfunction

    function automatic void apply_register(input logic [PADDR_W-1:0] addr,
                                           input logic [PDATA_W-1:0] data);
        case (addr[3:2])
            REG_POOL_BASE: begin
                base_reg = data[ADDR_W-1:0];
            end
            REG_BLOCK_SIZE: begin
                size_reg = data[BSIZE_W-1:0];
            end
            REG_NUM_BLOCKS: begin
                // saturate at the pool limit, then reload
                nblk_reg = (data[NBLK_W-1:0] > MAX_BLOCKS) ? NBLK_W'(MAX_BLOCKS)
                                                           : data[NBLK_W-1:0];
                refill_pool();
            end
            default: begin
            end
        endcase
    endfunction

    // Work out the result beat of one request and advance the shadow pool.
    function automatic t_result pool_step(input logic op, input logic [ADDR_W-1:0] addr);
        t_result           r;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] quot;
        logic [IDX_W-1:0]  idx;
        bit                ok;
        r.status   = ST_OK;
        r.blk_addr = '0;
        quot       = '0;
        if (op == OP_ALLOC) begin
            if (free_depth == 0 || free_depth > MAX_BLOCKS) begin
                r.status = ST_EMPTY;
            end else begin
                free_depth    = free_depth - 1'b1;
                idx           = free_idx[free_depth[IDX_W-1:0]];
                busy_map[idx] = 1'b1;
                r.blk_addr    = base_reg + ADDR_W'(idx) * ADDR_W'(size_reg);
            end
        end else begin
            ok = 1'b1;
            if (addr < base_reg || size_reg == 0) begin
                ok = 1'b0;
            end else begin
                offset = addr - base_reg;
                if (offset % size_reg != 0) begin
                    ok = 1'b0;
                end else begin
                    quot = offset / size_reg;
                    if (quot >= ADDR_W'(nblk_reg) || quot >= MAX_BLOCKS)
                        ok = 1'b0;
                    else if (!busy_map[quot[IDX_W-1:0]])
                        ok = 1'b0;
                end
            end
            if (ok && free_depth < MAX_BLOCKS) begin
                busy_map[quot[IDX_W-1:0]]         = 1'b0;
                free_idx[free_depth[IDX_W-1:0]]   = quot[IDX_W-1:0];
                free_depth                        = free_depth + 1'b1;
            end else begin
                r.status = ST_BADFREE;
            end
        end
        r.map   = busy_map;
        r.count = free_depth;
        return r;
    endfunction

    // Check result beats against the oldest expectation, then log new requests.
    // Results leave before requests enter so a same-edge pair stays in order.
    always @(posedge i_clk) begin : track_beats
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got.status   = o_status;
                got.blk_addr = o_block_addr;
                got.map      = o_alloc_map;
                got.count    = o_free_count;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: status %0d addr %h map %h count %0d",
                                 got.status, got.blk_addr, got.map, got.count);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  status     exp %0d got %0d", want.status, got.status);
                            $display("  block_addr exp %h got %h", want.blk_addr, got.blk_addr);
                            $display("  alloc_map  exp %h got %h", want.map, got.map);
                            $display("  free_count exp %0d got %0d", want.count, got.count);
                        end
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                want = pool_step(i_op, i_addr);
                if (pin_on) begin
                    want.status   = pin_value.status;
                    want.blk_addr = pin_value.blk_addr;
                    want.count    = pin_value.count;
                end
                pending_results = {pending_results, want};
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off once armed.
    initial begin : result_sink
        int held_cycles;
        held_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (hold_arm && held_cycles < HOLD_CYCLES) begin
                i_out_stall <= 1'b1;
                held_cycles++;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // Offer one request beat after a random gap; return at the accepting edge.
    // Valid stays high on return so back-to-back beats need no extra assignment.
    task automatic send_request(input logic op, input logic [ADDR_W-1:0] addr,
                                input bit pinned, input t_result pin);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_addr     <= addr;
        pin_on     <= pinned;
        pin_value  <= pin;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and wait until every expected result beat has come back.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Setup cycle, access cycle, then the bus goes idle.
    task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_register(addr, data);
        @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: allocations and frees of in-range block
    // addresses, with a slice of malformed frees mixed in.
    task automatic pick_request(output logic op, output logic [ADDR_W-1:0] addr,
                                input int alloc_pct);
        int roll;
        int slot;
        roll = $urandom_range(0, 99);
        slot = (nblk_reg == 0) ? 0 : $urandom_range(0, nblk_reg - 1);
        op   = OP_FREE;
        if (roll < alloc_pct) begin
            op   = OP_ALLOC;
            addr = $urandom;
        end else if (roll < 88) begin
            addr = base_reg + ADDR_W'(slot) * ADDR_W'(size_reg);
        end else begin
            case ($urandom_range(0, 3))
                0: addr = $urandom;
                1: begin
                    if (size_reg > 1)
                        addr = base_reg + ADDR_W'(slot) * ADDR_W'(size_reg)
                             + ADDR_W'($urandom_range(1, size_reg - 1));
                    else
                        addr = $urandom;
                end
                2: addr = base_reg
                        + ADDR_W'(nblk_reg + $urandom_range(0, 3)) * ADDR_W'(size_reg);
                default: addr = base_reg - ADDR_W'($urandom_range(1, 16));
            endcase
        end
    endtask

    initial begin : run_test
        int                    alloc_pct;
        int                    mode;
        logic                  op;
        logic [ADDR_W-1:0]     addr;
        logic [PDATA_W-1:0]    seg_base;
        logic [PDATA_W-1:0]    seg_size;
        logic [PDATA_W-1:0]    seg_count;
        t_result               pin;

        // shadow starts from the reset state
        base_reg = RST_POOL_BASE;
        size_reg = RST_BLOCK_SIZE;
        nblk_reg = RST_NUM_BLOCKS;
        refill_pool();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table; register writes only with the pipe empty.
        for (int s = 0; s < NUM_STEPS; s++) begin
            if (DIRECTED_STEPS[s].kind == ROW_CFG) begin
                wait_drain();
                cfg_write(DIRECTED_STEPS[s].cfg_addr, DIRECTED_STEPS[s].cfg_data);
            end else begin
                pin          = '0;
                pin.status   = DIRECTED_STEPS[s].status;
                pin.blk_addr = DIRECTED_STEPS[s].blk_addr;
                pin.count    = DIRECTED_STEPS[s].count;
                send_request(DIRECTED_STEPS[s].op, DIRECTED_STEPS[s].addr,
                             DIRECTED_STEPS[s].pinned, pin);
            end
        end
        wait_drain();

        // Random segments. Idle mode advances every two segments: sender light
        // and receiver heavy, then the reverse, then neither idles.
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            mode = seg / 2;
            sender_idle_pct = (mode == 0) ? 10 : (mode == 1) ? 82 : 0;
            recv_idle_pct   = (mode == 0) ? 82 : (mode == 1) ? 10 : 0;

            if (seg == 0) begin
                seg_base  = '0;
                seg_size  = 32'd1;
                seg_count = 32'd64;
            end else if (seg == NUM_SEGMENTS - 1) begin
                // top of the address space, largest blocks
                seg_base  = 32'hFFFF_FFFF;
                seg_size  = 32'h0000_FFFF;
                seg_count = 32'd64;
            end else begin
                case ($urandom_range(0, 2))
                    0: seg_base = '0;
                    1: seg_base = 32'hFFFF_0000 | $urandom_range(0, 32'hFFFF);
                    default: seg_base = $urandom;
                endcase
                case ($urandom_range(0, 3))
                    0: seg_size = 32'd1;
                    1: seg_size = 32'h0000_FFFF;
                    2: seg_size = $urandom_range(2, 64);
                    default: seg_size = $urandom_range(1, 65535);
                endcase
                case ($urandom_range(0, 3))
                    0: seg_count = 32'd1;
                    1: seg_count = 32'd64;
                    default: seg_count = $urandom_range(2, 12);
                endcase
            end
            cfg_write({REG_POOL_BASE, 2'b00}, seg_base);
            cfg_write({REG_BLOCK_SIZE, 2'b00}, seg_size);
            cfg_write({REG_NUM_BLOCKS, 2'b00}, seg_count);

            // Hold the result side off while requests keep coming, so the
            // block backs up and stalls its input.
            if (seg == HOLD_SEGMENT)
                hold_arm <= 1'b1;

            alloc_pct = 50;
            for (int k = 0; k < SEG_ITEMS; k++) begin
                // swing the allocate share per burst to walk the pool full and empty
                if (k % BURST_LEN == 0)
                    alloc_pct = $urandom_range(15, 80);
                pick_request(op, addr, alloc_pct);
                send_request(op, addr, 1'b0, '0);
            end
            wait_drain();
        end

        // Let any stray beat show up before the verdict.
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("fixed_block_pool_allocator regression: pass");
        else
            $display("fixed_block_pool_allocator regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
